FILE: hw/rtl/swmac_pkg.sv
package swmac_pkg;

  localparam int DEF_MAX_WINDOW  = 64;
  localparam int DEF_SAMPLE_BITS = 32;
  localparam int LEN_W           = 7;
  localparam int IN_W            = 32;
  localparam int COST_W          = 38;
  localparam int MEDIAN_W        = 32;
  localparam logic [LEN_W-1:0] LEN_RESET = 7'd16;

  // controller to datapath
  typedef struct packed {
    logic latch;     // capture the sample and read the oldest ring slot
    logic upd;       // update sorted cells, ring and counters
    logic scan_step; // take one scan element into the cost sum
    logic out_load;  // move the finished result into the output registers
    logic cfg_wr;    // write the window length and empty the window
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic result;    // the item being updated produces a result
    logic scan_last; // the current scan element is the last of the window
  } sts_t;

endpackage

FILE: hw/rtl/swmac_ctrl.sv
module swmac_ctrl
  import swmac_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_take;

  assign in_take   = in_valid && (state_r == ST_IDLE);
  assign in_stall  = (state_r != ST_IDLE);
  // hold the length write off while a sample is being processed or offered
  assign cfg_ready = (state_r == ST_IDLE) && !in_valid;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.latch      = in_take;
    cmd.cfg_wr     = cfg_valid && cfg_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_take) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.upd   = 1'b1;
        state_nxt = sts.result ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // hold the sum until the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = cmd.out_load ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_take_update: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> state_r == ST_UPDATE)
    else $error("accepted sample not followed by update");

  a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE) && !sts.result |=> state_r == ST_IDLE)
    else $error("filling sample did not return to idle");

  a_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) && sts.scan_last |=> state_r == ST_DONE)
    else $error("scan end missed");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("loaded result not presented");

endmodule

FILE: hw/rtl/swmac_dp.sv
module swmac_dp
  import swmac_pkg::*;
#(
  parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cmd_t                       cmd,
  output sts_t                       sts,
  input  logic [IN_W-1:0]            in_sample,
  input  logic [LEN_W-1:0]           cfg_window_len,
  output logic [COST_W-1:0]          out_cost,
  output logic signed [MEDIAN_W-1:0] out_median
);

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int ACC_W = SAMPLE_BITS + CNT_W + 2;

  typedef logic signed [SAMPLE_BITS-1:0] smp_t;

  logic [LEN_W-1:0] len_cfg_r;
  logic [CNT_W-1:0] len, mid, fill_r, ins_n, cnt_r;
  logic [PTR_W-1:0] ptr_r, wr_addr;
  logic             steady;
  smp_t             x_r, old_r, med_r;
  smp_t             ring [MAX_WINDOW];
  smp_t             cells_r [MAX_WINDOW];
  smp_t             del   [MAX_WINDOW];
  smp_t             cells_nxt [MAX_WINDOW];
  smp_t             scan_r [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] gt;
  logic signed [ACC_W-1:0] acc_r, elem;
  logic signed [COST_W-1:0] cost_r;

  always_comb begin
    if (len_cfg_r == '0) len = CNT_W'(1);
    else if (32'(len_cfg_r) > MAX_WINDOW) len = CNT_W'(MAX_WINDOW);
    else len = CNT_W'(len_cfg_r);
  end

  assign mid     = (len - CNT_W'(1)) >> 1;
  assign steady  = (fill_r == len);
  assign ins_n   = steady ? (len - CNT_W'(1)) : fill_r;
  assign wr_addr = steady ? ptr_r : fill_r[PTR_W-1:0];

  assign sts.result    = steady || (fill_r + CNT_W'(1) == len);
  assign sts.scan_last = (cnt_r == len - CNT_W'(1));

  // once the window is full drop the oldest sample, then insert the new one, all cells at once
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    if (i == MAX_WINDOW - 1) begin : g_top
      assign del[i] = cells_r[i];
    end else begin : g_mid
      assign del[i] = (steady && !(cells_r[i] < old_r)) ? cells_r[i+1] : cells_r[i];
    end
    assign gt[i] = (CNT_W'(i) < ins_n) ? (del[i] > x_r) : 1'b1;
    if (i == 0) begin : g_first
      assign cells_nxt[i] = gt[i] ? x_r : del[i];
    end else begin : g_rest
      assign cells_nxt[i] = !gt[i] ? del[i] : (gt[i-1] ? del[i-1] : x_r);
    end
    always_ff @(posedge clk) begin
      if (cmd.upd) cells_r[i] <= cells_nxt[i];
      if (cmd.upd) scan_r[i] <= cells_nxt[i];
      else if (cmd.scan_step) begin
        if (i == MAX_WINDOW - 1) scan_r[i] <= scan_r[i];
        else scan_r[i] <= scan_r[(i + 1) % MAX_WINDOW];
      end
    end
  end

  assign elem = ACC_W'(scan_r[0]);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      x_r   <= smp_t'(in_sample[SAMPLE_BITS-1:0]);
      old_r <= ring[ptr_r];
    end
    if (cmd.upd) ring[wr_addr] <= x_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_cfg_r <= LEN_RESET;
      fill_r    <= '0;
      ptr_r     <= '0;
      cnt_r     <= '0;
    end else begin
      if (cmd.cfg_wr) begin
        len_cfg_r <= cfg_window_len;
        fill_r    <= '0;
        ptr_r     <= '0;
      end else if (cmd.upd) begin
        if (steady) begin
          ptr_r <= (ptr_r + PTR_W'(1) == len[PTR_W-1:0] || len == CNT_W'(1)) ? '0
                                                                       : ptr_r + PTR_W'(1);
        end else begin
          fill_r <= fill_r + CNT_W'(1);
        end
      end
      if (cmd.upd) cnt_r <= '0;
      else if (cmd.scan_step) cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // upper half adds, lower half subtracts; an even window subtracts the median once
  always_ff @(posedge clk) begin
    if (cmd.upd) acc_r <= '0;
    else if (cmd.scan_step) begin
      if (cnt_r < mid) acc_r <= acc_r - elem;
      else if (cnt_r > mid) acc_r <= acc_r + elem;
      else begin
        med_r <= scan_r[0];
        if (!len[0]) acc_r <= acc_r - elem;
      end
    end
    if (cmd.out_load) begin
      cost_r     <= COST_W'(acc_r);
      out_median <= MEDIAN_W'(med_r);
    end
  end

  assign out_cost = cost_r;

endmodule

FILE: hw/rtl/sliding_window_median_abs_cost_unit.sv
// Sliding-window median and absolute-deviation cost. Each sample enters a window of
// cfg_window_len samples (0 reads as 1, values above MAX_WINDOW saturate); once the window
// is full every sample yields the lower median and the sum of absolute differences from it,
// while filling samples yield nothing. A length write empties the window. For each sample
// the sorted cells drop and insert all at once; when a result is due, a single accumulator
// then walks the window one element a cycle. The next sample is taken while a result waits
// in the output register.
module sliding_window_median_abs_cost_unit
  import swmac_pkg::*;
#(
  parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [IN_W-1:0]     in_sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [COST_W-1:0]          out_cost,
  output logic signed [MEDIAN_W-1:0] out_median,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [LEN_W-1:0]           cfg_window_len
);

  cmd_t cmd;
  sts_t sts;

  swmac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  swmac_dp #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_sample      (in_sample),
    .cfg_window_len (cfg_window_len),
    .out_cost       (out_cost),
    .out_median     (out_median)
  );

endmodule
